@@ design/bitmap_shape_fill_engine_unit_defines.svh @@
// Assertion macros shared by the checker of the shape fill engine.
// No dependencies; included by files that assert.
`ifndef BITMAP_SHAPE_FILL_ENGINE_UNIT_DEFINES_SVH
`define BITMAP_SHAPE_FILL_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BSFE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsfe check failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define BSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsfe check failed: next-cycle implication");

`endif

@@ design/bsfe_pkg.sv @@
// Shared types and constants of the bitmap shape fill engine.
// No dependencies; used by every module of the engine but bsfe_ram.
package bsfe_pkg;

   // Default sizes of the pixel store
   localparam int DEFAULT_MAX_WIDTH  = 64;
   localparam int DEFAULT_MAX_HEIGHT = 64;

   // Fixed field widths
   localparam int ROW_W      = 64;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int COORD_W    = 13;

   localparam logic [CSR_DATA_W-1:0] CANVAS_RESET = 7'd64;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Command codes
   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_SET     = 3'd1,
      CMD_RECT    = 3'd2,
      CMD_DIAMOND = 3'd3,
      CMD_READ    = 3'd4
   } cmd_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // capture the request fields
      logic row_clear;  // restart the row counter
      logic row_step;   // advance the row counter
      logic sweep;      // write a zero row at the counter
      logic fill_rd;    // read the counter row for a fill
      logic read_rd;    // read the requested row
      logic emit_zero;  // send an all-zero result
      logic emit_read;  // send the read row
   } ctrl_type;

   // Datapath to controller status
   typedef struct packed {
      logic fill_last;     // counter at the last canvas row
      logic sweep_last;    // counter at the last store row
      logic canvas_empty;  // effective height is zero
      logic read_in_range; // requested row lies inside the canvas
   } stat_type;

endpackage

@@ design/bsfe_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bsfe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bsfe_ctrl.sv @@
// Controller state machine of the shape fill engine.
// Depends on bsfe_pkg; drives the datapath through ctrl_type.
module bsfe_ctrl
   import bsfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] req_command,
   input  stat_type   stat,
   output ctrl_type   ctrl,
   output logic       busy
);

   typedef enum logic [6:0] {
      ST_INIT     = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_CLEAR    = 7'b0000100,
      ST_FILL     = 7'b0001000,
      ST_DRAIN    = 7'b0010000,
      ST_READ     = 7'b0100000,
      ST_READ_OUT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_INIT: begin
            ctrl.sweep    = 1'b1;
            ctrl.row_step = 1'b1;
            if (stat.sweep_last) begin
               ctrl.row_clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctrl.load      = 1'b1;
               ctrl.row_clear = 1'b1;
               case (cmd_type'(req_command))
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_SET, CMD_RECT, CMD_DIAMOND: begin
                     if (stat.canvas_empty) begin
                        ctrl.emit_zero = 1'b1;
                     end else begin
                        state_in = ST_FILL;
                     end
                  end
                  CMD_READ: begin
                     if (stat.read_in_range) begin
                        state_in = ST_READ;
                     end else begin
                        ctrl.emit_zero = 1'b1;
                     end
                  end
                  default: ctrl.emit_zero = 1'b1;
               endcase
            end
         end
         ST_CLEAR: begin
            ctrl.sweep    = 1'b1;
            ctrl.row_step = 1'b1;
            if (stat.sweep_last) begin
               ctrl.row_clear = 1'b1;
               ctrl.emit_zero = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_FILL: begin
            ctrl.fill_rd  = 1'b1;
            ctrl.row_step = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last row write lands in this cycle
            ctrl.emit_zero = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_READ: begin
            ctrl.read_rd = 1'b1;
            state_in     = ST_READ_OUT;
         end
         ST_READ_OUT: begin
            ctrl.emit_read = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ design/bsfe_datapath.sv @@
// Datapath of the shape fill engine: canvas registers, row walker,
// span mask pipeline, pixel store and result registers.
// Depends on bsfe_pkg and bsfe_ram.
module bsfe_datapath
   import bsfe_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_type              ctrl,
   output stat_type              stat,
   input  logic [2:0]            req_command,
   input  logic signed [10:0]    req_pos_x,
   input  logic signed [10:0]    req_pos_y,
   input  logic [9:0]            req_rect_width,
   input  logic [9:0]            req_rect_height,
   input  logic signed [10:0]    req_radius,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                  rsp_strobe,
   output logic [ROW_W-1:0]      rsp_row_bits,
   output logic                  rsp_row_valid
);

   localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam logic [ROW_W-1:0] ONES = {ROW_W{1'b1}};

   // Canvas registers
   logic [CSR_DATA_W-1:0] canvas_width_ff, canvas_height_ff;
   logic [CSR_DATA_W-1:0] eff_w;
   logic [HW-1:0]         eff_h;

   // Captured command
   logic                  diamond_ff;
   logic                  shape_ok_ff;
   logic signed [10:0]    px_ff, py_ff, rad_ff;
   coord_type             xh_ff, yh_ff;
   logic                  diamond_in, shape_ok_in;
   coord_type             xh_in, yh_in;

   // Row walker and span pipeline
   logic [AW-1:0]         row_ff, row_in;
   logic                  s1_valid_ff;
   logic                  s1_hit_ff, s1_hit_in;
   coord_type             s1_lo_ff, s1_lo_in, s1_hi_ff, s1_hi_in;
   logic [AW-1:0]         s1_row_ff;
   coord_type             y_s, px_s, py_s, rad_s, dy, hw;
   coord_type             lo_c, hi_c, w_m1;
   logic [ROW_W-1:0]      span;

   // Store ports
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [MAX_WIDTH-1:0]  wr_data, rd_data;

   // Result registers
   logic                  rsp_strobe_ff;
   logic [ROW_W-1:0]      rsp_row_bits_ff, rsp_row_bits_in;
   logic                  rsp_row_valid_ff;
   logic [ROW_W-1:0]      width_mask;

   // Write canvas registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= CANVAS_RESET;
         canvas_height_ff <= CANVAS_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == REG_CANVAS_WIDTH) begin
            canvas_width_ff <= csr_write_data;
         end else if (csr_index == REG_CANVAS_HEIGHT) begin
            canvas_height_ff <= csr_write_data;
         end
      end
   end

   // Effective canvas: clamp to the store size
   always_comb begin
      if (32'(canvas_width_ff) < MAX_WIDTH) begin
         eff_w = canvas_width_ff;
      end else begin
         eff_w = CSR_DATA_W'(MAX_WIDTH);
      end
      if (32'(canvas_height_ff) < MAX_HEIGHT) begin
         eff_h = HW'(canvas_height_ff);
      end else begin
         eff_h = HW'(MAX_HEIGHT);
      end
   end

   // Status to the controller
   always_comb begin
      stat.fill_last     = ((HW'(row_ff) + HW'(1)) == eff_h);
      stat.sweep_last    = ((HW'(row_ff) + HW'(1)) == HW'(MAX_HEIGHT));
      stat.canvas_empty  = (eff_h == '0);
      stat.read_in_range = !req_pos_y[10] && ({2'b00, req_pos_y[9:0]} < 12'(eff_h));
   end

   // Turn the request into a column and row span; a point is a 1x1 rectangle
   always_comb begin
      diamond_in  = (cmd_type'(req_command) == CMD_DIAMOND);
      xh_in       = $signed({{2{req_pos_x[10]}}, req_pos_x})
                  + $signed({3'b000, req_rect_width}) - coord_type'(1);
      yh_in       = $signed({{2{req_pos_y[10]}}, req_pos_y})
                  + $signed({3'b000, req_rect_height}) - coord_type'(1);
      shape_ok_in = (req_rect_width != '0) && (req_rect_height != '0);
      case (cmd_type'(req_command))
         CMD_SET: begin
            xh_in       = $signed({{2{req_pos_x[10]}}, req_pos_x});
            yh_in       = $signed({{2{req_pos_y[10]}}, req_pos_y});
            shape_ok_in = 1'b1;
         end
         CMD_DIAMOND: shape_ok_in = !req_radius[10];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         diamond_ff  <= diamond_in;
         shape_ok_ff <= shape_ok_in;
         px_ff       <= req_pos_x;
         py_ff       <= req_pos_y;
         rad_ff      <= req_radius;
         xh_ff       <= xh_in;
         yh_ff       <= yh_in;
      end
   end

   // Advance the row counter
   always_comb begin
      row_in = row_ff;
      if (ctrl.row_clear) begin
         row_in = '0;
      end else if (ctrl.row_step) begin
         row_in = row_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   // Span stage: column range and hit of the current row
   always_comb begin
      y_s   = $signed(COORD_W'(row_ff));
      px_s  = $signed({{2{px_ff[10]}}, px_ff});
      py_s  = $signed({{2{py_ff[10]}}, py_ff});
      rad_s = $signed({{2{rad_ff[10]}}, rad_ff});
      dy    = (y_s >= py_s) ? (y_s - py_s) : (py_s - y_s);
      hw    = rad_s - dy;
      if (diamond_ff) begin
         s1_hit_in = shape_ok_ff && !hw[COORD_W-1];
         s1_lo_in  = px_s - hw;
         s1_hi_in  = px_s + hw;
      end else begin
         s1_hit_in = shape_ok_ff && (y_s >= py_s) && (y_s <= yh_ff);
         s1_lo_in  = px_s;
         s1_hi_in  = xh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.fill_rd;
      end
   end

   always_ff @(posedge clock) begin
      s1_hit_ff <= s1_hit_in;
      s1_lo_ff  <= s1_lo_in;
      s1_hi_ff  <= s1_hi_in;
      s1_row_ff <= row_ff;
   end

   // Mask stage: clip to the canvas and build the column mask
   always_comb begin
      w_m1 = $signed(COORD_W'(eff_w)) - coord_type'(1);
      lo_c = s1_lo_ff[COORD_W-1] ? coord_type'(0) : s1_lo_ff;
      hi_c = (s1_hi_ff > w_m1) ? w_m1 : s1_hi_ff;
      if (!s1_hit_ff || (lo_c > hi_c)) begin
         span = '0;
      end else begin
         span = (ONES >> (6'd63 - hi_c[5:0])) & (ONES << lo_c[5:0]);
      end
   end

   // Store: sweep writes zero rows, fills merge the span into the row read back
   always_comb begin
      wr_en   = ctrl.sweep || s1_valid_ff;
      wr_addr = ctrl.sweep ? row_ff : s1_row_ff;
      wr_data = ctrl.sweep ? '0 : (rd_data | span[MAX_WIDTH-1:0]);
      rd_en   = ctrl.fill_rd || ctrl.read_rd;
      rd_addr = ctrl.fill_rd ? row_ff : py_ff[AW-1:0];
   end

   bsfe_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT),
      .ADDR_W(AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Result: read row masked to the effective width, zero otherwise
   always_comb begin
      if (eff_w == '0) begin
         width_mask = '0;
      end else begin
         width_mask = ONES >> (7'd64 - eff_w);
      end
      rsp_row_bits_in = ctrl.emit_read ? (ROW_W'(rd_data) & width_mask) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.emit_zero || ctrl.emit_read;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_bits_ff  <= rsp_row_bits_in;
      rsp_row_valid_ff <= ctrl.emit_read;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_row_bits  = rsp_row_bits_ff;
   assign rsp_row_valid = rsp_row_valid_ff;

endmodule

@@ design/bitmap_shape_fill_engine_unit.sv @@
// Top level of the bitmap shape fill engine.
// Depends on bsfe_pkg, bsfe_ctrl and bsfe_datapath.
//
// One-bit-per-pixel bitmap of MAX_HEIGHT rows by MAX_WIDTH columns with
// clear, set point, rectangle fill, diamond fill and row readout. A command
// transfers at a rising edge with start high and busy low; every command
// gives exactly one result, shown for one cycle with rsp_strobe high, and
// the receiver cannot stall it. A clear sweeps every store row; a fill
// walks the rows of the effective canvas height with a read-modify-write
// walk that handles one row per cycle through the store's single write
// port; a read in range reads the store row and then sends it; reads out
// of range, unknown commands and fills of an empty canvas answer straight
// from idle. busy drops in the strobe cycle, so a new command may transfer
// while the result is shown. After reset a clearing pass zeroes the store
// with busy high; canvas register writes are taken at any time but must
// only be made while the block is idle.
module bitmap_shape_fill_engine_unit
   import bsfe_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_command,
   input  logic signed [10:0]    req_pos_x,
   input  logic signed [10:0]    req_pos_y,
   input  logic [9:0]            req_rect_width,
   input  logic [9:0]            req_rect_height,
   input  logic signed [10:0]    req_radius,
   output logic                  rsp_strobe,
   output logic [ROW_W-1:0]      rsp_row_bits,
   output logic                  rsp_row_valid,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   ctrl_type ctrl;
   stat_type stat;

   bsfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_command(req_command),
      .stat       (stat),
      .ctrl       (ctrl),
      .busy       (busy)
   );

   bsfe_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_command     (req_command),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_radius      (req_radius),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_row_bits    (rsp_row_bits),
      .rsp_row_valid   (rsp_row_valid)
   );

endmodule

@@ design/bsfe_checker.sv @@
// Port-level checker of the shape fill engine, bound to the top level.
// Depends on bsfe_pkg and the assertion macros header.
`include "bitmap_shape_fill_engine_unit_defines.svh"

module bsfe_checker
   import bsfe_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input logic [ROW_W-1:0]      rsp_row_bits,
   input logic                  rsp_row_valid
);

   // A transfer either keeps the block busy or answers at once
   `BSFE_ASSERT_NEXT(a_transfer_progress, clock, reset, start && !busy, busy || rsp_strobe)

   // A valid row only travels with its strobe
   `BSFE_ASSERT_IMPLY(a_valid_has_strobe, clock, reset, rsp_row_valid, rsp_strobe)

   // Set row bits only appear on a valid read row
   `BSFE_ASSERT_IMPLY(a_bits_need_valid, clock, reset, rsp_row_bits != '0, rsp_row_valid)

   // A result always follows a transfer or a busy cycle
   `BSFE_ASSERT_IMPLY(a_strobe_has_cause, clock, reset, rsp_strobe, $past(busy || start))

endmodule

bind bitmap_shape_fill_engine_unit bsfe_checker u_bsfe_checker (.*);

@@ sim/bitmap_mirror_pkg.sv @@
// Scoreboard of the bitmap shape fill engine: a mirror of the pixel store and
// a queue of expected row results. Depends on bsfe_pkg for sizes and codes.
package bitmap_mirror_pkg;
   import bsfe_pkg::*;

   class bitmap_mirror;
      typedef struct packed {
         logic [ROW_W-1:0] bits;
         logic             valid;
      } row_result_type;

      logic [ROW_W-1:0] rows [DEFAULT_MAX_HEIGHT];
      int               canvas_w;
      int               canvas_h;
      row_result_type   pending_rows [$];
      int               mismatches;
      int               results_seen;
      int               reads;
      int               valid_reads;

      function new();
         foreach (rows[i]) rows[i] = '0;
         canvas_w     = CANVAS_RESET;
         canvas_h     = CANVAS_RESET;
         mismatches   = 0;
         results_seen = 0;
         reads        = 0;
         valid_reads  = 0;
      endfunction

      // Register writes with an index beyond the canvas pair are dropped
      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_CANVAS_WIDTH) canvas_w = value;
         else if (idx == REG_CANVAS_HEIGHT) canvas_h = value;
      endfunction

      function int used_width();
         return (canvas_w < DEFAULT_MAX_WIDTH) ? canvas_w : DEFAULT_MAX_WIDTH;
      endfunction

      function int used_height();
         return (canvas_h < DEFAULT_MAX_HEIGHT) ? canvas_h : DEFAULT_MAX_HEIGHT;
      endfunction

      // Columns lo..hi, clipped to the used width
      function logic [ROW_W-1:0] col_span(int lo, int hi, int w);
         logic [ROW_W-1:0] ones;
         ones = '1;
         if (lo < 0) lo = 0;
         if (hi > w - 1) hi = w - 1;
         if (lo > hi) return '0;
         return (ones >> (ROW_W - 1 - hi)) & (ones << lo);
      endfunction

      // Apply one accepted command to the mirror and queue its result
      function void note_command(logic [2:0] cmd, logic signed [10:0] px,
                                 logic signed [10:0] py, logic [9:0] rw,
                                 logic [9:0] rh, logic signed [10:0] rad);
         int             w, h, x, y, wd, ht, r, row, dy, half;
         row_result_type res;
         w   = used_width();
         h   = used_height();
         x   = px;
         y   = py;
         wd  = rw;
         ht  = rh;
         r   = rad;
         res = '0;
         case (cmd)
            CMD_CLEAR: begin
               foreach (rows[i]) rows[i] = '0;
            end
            CMD_SET: begin
               if (y >= 0 && y < h) rows[y] |= col_span(x, x, w);
            end
            CMD_RECT: begin
               if (wd > 0 && ht > 0)
                  for (row = 0; row < h; row++)
                     if (row >= y && row <= y + ht - 1) rows[row] |= col_span(x, x + wd - 1, w);
            end
            CMD_DIAMOND: begin
               if (r >= 0)
                  for (row = 0; row < h; row++) begin
                     dy   = (row >= y) ? row - y : y - row;
                     half = r - dy;
                     if (half >= 0) rows[row] |= col_span(x - half, x + half, w);
                  end
            end
            CMD_READ: begin
               reads++;
               if (y >= 0 && y < h) begin
                  res.bits  = rows[y] & col_span(0, w - 1, w);
                  res.valid = 1'b1;
                  valid_reads++;
               end
            end
            default: ;
         endcase
         pending_rows.push_back(res);
      endfunction

      function void report(string field, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     results_seen, field, want, got);
      endfunction

      // Compare one strobed result with the oldest expectation
      function void check_row_result(logic [ROW_W-1:0] bits, logic valid);
         row_result_type want;
         results_seen++;
         if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with nothing pending: %h / %b",
                        results_seen, bits, valid);
            return;
         end
         want = pending_rows.pop_front();
         if (bits !== want.bits) report("row_bits", want.bits, bits);
         if (valid !== want.valid) report("row_valid", want.valid, valid);
      endfunction
   endclass

endpackage

@@ sim/tb.sv @@
// Testbench top of the bitmap shape fill engine: drives commands and canvas
// settings, checks every result. Depends on bsfe_pkg and bitmap_mirror_pkg.
module tb;
   import bsfe_pkg::*;
   import bitmap_mirror_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int PHASES           = 10;
   localparam int ITEMS_PER_PHASE  = 75;
   localparam int TAIL_CYCLES      = DEFAULT_MAX_HEIGHT + 8;
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 2'd2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [2:0]            req_command = '0;
   logic signed [10:0]    req_pos_x = '0;
   logic signed [10:0]    req_pos_y = '0;
   logic [9:0]            req_rect_width = '0;
   logic [9:0]            req_rect_height = '0;
   logic signed [10:0]    req_radius = '0;
   logic                  rsp_strobe;
   logic [ROW_W-1:0]      rsp_row_bits;
   logic                  rsp_row_valid;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   bitmap_mirror mirror = new();
   int cycle_count = 0;
   int issued = 0;
   int settings = 0;
   int sender_idle_pct = 0;

   bitmap_shape_fill_engine_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_radius       (req_radius),
      .rsp_strobe       (rsp_strobe),
      .rsp_row_bits     (rsp_row_bits),
      .rsp_row_valid    (rsp_row_valid),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, mirror.pending_rows.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // Check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_strobe) mirror.check_row_result(rsp_row_bits, rsp_row_valid);
   end

   // Present one command and hold it until the transfer
   task automatic issue(input logic [2:0] cmd, input logic signed [10:0] x,
                        input logic signed [10:0] y, input logic [9:0] w,
                        input logic [9:0] h, input logic signed [10:0] r);
      req_command     <= cmd;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_rect_width  <= w;
      req_rect_height <= h;
      req_radius      <= r;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      mirror.note_command(cmd, x, y, w, h, r);
      issued++;
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop sending until every expected result is back and the block is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.pending_rows.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Write both canvas registers, then a spare index that must be dropped
   task automatic write_canvas(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      logic [CSR_IDX_W-1:0]  spare;
      logic [CSR_DATA_W-1:0] junk;
      spare = REG_SPARE_FIRST + CSR_IDX_W'($urandom_range(0, 1));
      junk  = CSR_DATA_W'($urandom);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_CANVAS_WIDTH;
      csr_write_data   <= w;
      @(posedge clock);
      mirror.set_register(REG_CANVAS_WIDTH, w);
      csr_index      <= REG_CANVAS_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      mirror.set_register(REG_CANVAS_HEIGHT, h);
      csr_index      <= spare;
      csr_write_data <= junk;
      @(posedge clock);
      mirror.set_register(spare, junk);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings++;
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 70);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic signed [10:0] near_canvas();
      return 11'(int'($urandom_range(0, 83)) - 10);
   endfunction

   // Mostly shapes and reads around the canvas, sometimes full-range fields
   task automatic random_item();
      logic [2:0]         cmd;
      logic signed [10:0] x, y, r;
      logic [9:0]         w, h;
      int                 pick;
      x    = 11'($urandom);
      y    = 11'($urandom);
      w    = 10'($urandom);
      h    = 10'($urandom);
      r    = 11'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 3) cmd = CMD_CLEAR;
      else if (pick < 15) cmd = CMD_SET;
      else if (pick < 30) cmd = CMD_RECT;
      else if (pick < 45) cmd = CMD_DIAMOND;
      else if (pick < 95) cmd = CMD_READ;
      else cmd = CMD_UNUSED_FIRST + 3'($urandom_range(0, 2));
      if ($urandom_range(0, 9) != 0) begin
         x = near_canvas();
         y = near_canvas();
      end
      if ($urandom_range(0, 9) != 0) w = 10'($urandom_range(0, 24));
      if ($urandom_range(0, 9) != 0) h = 10'($urandom_range(0, 24));
      if ($urandom_range(0, 9) != 0) r = 11'(int'($urandom_range(0, 24)) - 3);
      issue(cmd, x, y, w, h, r);
   endtask

   initial begin : stimulus
      int plan_w [PHASES];
      int plan_h [PHASES];
      int phase, n, cw, ch, leftover, failed;
      plan_w = '{64, 1, 17, 64, 1, 127, 0, 40, 0, 64};
      plan_h = '{64, 1, 40, 1, 64, 127, 5, 0, 0, 64};

      // Reset, then let the clearing pass finish
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
      write_canvas(CANVAS_RESET, CANVAS_RESET);

      // Directed: clipping at every edge, empty shapes, reads out of range
      issue(CMD_READ, 0, 0, 0, 0, 0);
      issue(CMD_SET, 0, 0, 0, 0, 0);
      issue(CMD_SET, 63, 63, 0, 0, 0);
      issue(CMD_SET, -1, 3, 0, 0, 0);
      issue(CMD_SET, 64, 3, 0, 0, 0);
      issue(CMD_SET, 1023, -1024, 1023, 1023, 1023);
      issue(CMD_RECT, -5, -5, 10, 10, 0);
      issue(CMD_RECT, 20, 20, 0, 5, 0);
      issue(CMD_RECT, 20, 20, 5, 0, 0);
      issue(CMD_RECT, 60, 58, 1023, 1023, 0);
      issue(CMD_RECT, -1024, -1024, 1023, 1023, 0);
      issue(CMD_DIAMOND, 40, 10, 0, 0, -1);
      issue(CMD_DIAMOND, 40, 10, 0, 0, -1024);
      issue(CMD_DIAMOND, 32, 32, 0, 0, 5);
      issue(CMD_DIAMOND, 1023, 1023, 0, 0, 1023);
      issue(CMD_READ, 0, 63, 0, 0, 0);
      issue(CMD_READ, 0, 64, 0, 0, 0);
      issue(CMD_READ, 0, -1, 0, 0, 0);
      issue(CMD_READ, 0, 1023, 0, 0, 0);
      issue(CMD_READ, 0, 32, 0, 0, 0);
      issue(CMD_UNUSED_FIRST, 1, 1, 1, 1, 1);
      issue(CMD_UNUSED_LAST, -1, -1, 1023, 1023, -1);

      // Shrink the canvas over drawn rows, read masked bits, then restore
      drain();
      write_canvas(7'd8, 7'd5);
      issue(CMD_READ, 0, 4, 0, 0, 0);
      issue(CMD_READ, 0, 5, 0, 0, 0);
      drain();
      write_canvas(CANVAS_RESET, CANVAS_RESET);
      issue(CMD_READ, 0, 2, 0, 0, 0);
      issue(CMD_CLEAR, 0, 0, 0, 0, 0);
      issue(CMD_READ, 0, 32, 0, 0, 0);

      // Random phases over canvas settings and sender idling
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         cw = plan_w[phase];
         ch = plan_h[phase];
         if (phase == 2) begin
            cw = $urandom_range(1, 64);
            ch = $urandom_range(1, 64);
         end
         write_canvas(CSR_DATA_W'(cw), CSR_DATA_W'(ch));
         sender_idle_pct = (phase < 4) ? 30 : (phase < 7) ? 75 : 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 49) == 0) drain();
            if ($urandom_range(0, 99) < sender_idle_pct) hold_off(pick_gap());
            random_item();
         end
      end

      // Wind down and judge
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      leftover = mirror.pending_rows.size();
      failed   = mirror.mismatches + leftover;
      if (leftover != 0) $display("%0d expected results never arrived", leftover);
      $display("sent %0d commands under %0d canvas settings; %0d row reads, %0d inside the canvas",
               issued, settings, mirror.reads, mirror.valid_reads);
      $display("%0d results checked, %0d mismatches", mirror.results_seen, mirror.mismatches);
      if (failed == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
